@@ src/hcm_pkg.sv @@
// ============================================================================
// hcm_pkg: shared types and constants for the hotkey combination matcher
// Item and result beats, table entry layout, controller command/status.
// ============================================================================
package hcm_pkg;

    // Table sizing
    localparam int MAX_COMBOS         = 16;
    localparam int MAX_KEYS_PER_COMBO = 4;
    localparam int KEY_CODES          = 256;
    localparam int MAX_RESULTS        = 16;

    // Fixed field widths of the beats
    localparam int KEY_FIELDS = 4;
    localparam int KEY_W      = 8;
    localparam int SIZE_W     = 3;
    localparam int GROUP_W    = 8;
    localparam int SLOT_W     = 4;
    localparam int RCOUNT_W   = 5;

    // Derived widths
    localparam int KEYS_USED_MAX = (MAX_KEYS_PER_COMBO < KEY_FIELDS) ?
                                   MAX_KEYS_PER_COMBO : KEY_FIELDS;
    localparam int IDX_W      = (MAX_COMBOS > 1) ? $clog2(MAX_COMBOS) : 1;
    localparam int CNT_W      = $clog2(MAX_COMBOS + 1);
    localparam int KEY_ADDR_W = $clog2(KEY_CODES);
    localparam int JIDX_W     = $clog2(KEY_FIELDS);
    localparam int JCNT_W     = $clog2(KEY_FIELDS + 1);
    localparam int MCNT_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_KEY_DOWN = 2'd0,
        KIND_KEY_UP   = 2'd1,
        KIND_ADD      = 2'd2,
        KIND_REMOVE   = 2'd3
    } item_kind_t;

    typedef enum logic [1:0] {
        RK_MATCH  = 2'd0,
        RK_ADD    = 2'd1,
        RK_REMOVE = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } add_status_t;

    typedef enum logic [1:0] {
        EMIT_MATCH      = 2'd0,
        EMIT_MATCH_LAST = 2'd1,
        EMIT_ADD        = 2'd2,
        EMIT_REMOVE     = 2'd3
    } emit_sel_t;

    // Input beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key_code;
        logic [KEY_W-1:0]  combo_key_a;
        logic [KEY_W-1:0]  combo_key_b;
        logic [KEY_W-1:0]  combo_key_c;
        logic [KEY_W-1:0]  combo_key_d;
        logic [SIZE_W-1:0] combo_size;
        logic [GROUP_W-1:0] group_tag;
    } hcm_item_t;

    // Result beat
    typedef struct packed {
        logic [1:0]          result_kind;
        logic [SLOT_W-1:0]   combo_slot;
        logic [GROUP_W-1:0]  combo_group;
        logic [1:0]          add_status;
        logic [RCOUNT_W-1:0] removed_count;
        logic                last;
    } hcm_result_t;

    // One stored combination
    typedef struct packed {
        logic [GROUP_W-1:0]                 group;
        logic [SIZE_W-1:0]                  size;
        logic [KEY_FIELDS-1:0][KEY_W-1:0]   keys;
    } hcm_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      key_wr;
        logic      scan_clr;
        logic      combo_rd;
        logic      key_rd;
        logic      scan_step;
        logic      match;
        logic      rm_keep;
        logic      rm_drop;
        logic      add_exec;
        logic      count_commit;
        logic      emit;
        emit_sel_t emit_sel;
    } hcm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        item_kind_t kind;
        logic       scan_done;
        logic       key_is_down;
        logic       keys_done;
        logic       group_hit;
        logic       pend_valid;
        logic       match_cap;
    } hcm_sts_t;

endpackage

@@ src/hcm_ram.sv @@
// ============================================================================
// hcm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module hcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hcm_ctrl.sv @@
// ============================================================================
// hcm_ctrl: sequencer for the hotkey combination matcher
// Dispatches each beat and steps the table walk for key-down and remove.
// ============================================================================
module hcm_ctrl import hcm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  hcm_sts_t sts,
    output hcm_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_KEY_CHK,
        S_SCAN_END,
        S_RM_RD,
        S_RM_CHK,
        S_RM_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = EMIT_MATCH;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.kind)
                    KIND_KEY_DOWN:
                    begin
                        cmd.key_wr   = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_RD;
                    end
                    KIND_KEY_UP:
                    begin
                        cmd.key_wr = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_ADD:
                    begin
                        cmd.add_exec = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_ADD;
                        state_next   = S_IDLE;
                    end
                    KIND_REMOVE:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_RM_RD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cmd.combo_rd = 1'b1;
                    state_next   = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                // every stored entry has at least one key
                cmd.key_rd = 1'b1;
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                priority if (!sts.key_is_down)
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else if (sts.keys_done)
                begin
                    // flush the previous match, hold this one as pending
                    cmd.match     = 1'b1;
                    cmd.emit      = sts.pend_valid;
                    cmd.emit_sel  = EMIT_MATCH;
                    cmd.scan_step = 1'b1;
                    state_next    = sts.match_cap ? S_SCAN_END : S_SCAN_RD;
                end
                else
                begin
                    cmd.key_rd = 1'b1;
                end
            end
            S_SCAN_END:
            begin
                cmd.emit     = sts.pend_valid;
                cmd.emit_sel = EMIT_MATCH_LAST;
                state_next   = S_IDLE;
            end
            S_RM_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_RM_END;
                end
                else
                begin
                    cmd.combo_rd = 1'b1;
                    state_next   = S_RM_CHK;
                end
            end
            S_RM_CHK:
            begin
                cmd.rm_drop   = sts.group_hit;
                cmd.rm_keep   = !sts.group_hit;
                cmd.scan_step = 1'b1;
                state_next    = S_RM_RD;
            end
            S_RM_END:
            begin
                cmd.count_commit = 1'b1;
                cmd.emit         = 1'b1;
                cmd.emit_sel     = EMIT_REMOVE;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Idle issues no table access and no result beat
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !(cmd.combo_rd || cmd.key_rd || cmd.emit))
        else $error("controller accessed tables or emitted while idle");

endmodule

@@ src/hcm_datapath.sv @@
// ============================================================================
// hcm_datapath: key map, combination table and walk counters
// Holds the stored state, evaluates adds and builds result beats.
// ============================================================================
module hcm_datapath import hcm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  hcm_item_t   item,
    input  hcm_cmd_t    cmd,
    output hcm_sts_t    sts,
    output logic        result_valid,
    output hcm_result_t result
);

    // Control registers
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [CNT_W-1:0]       i_reg,       i_next;
    logic [CNT_W-1:0]       w_reg,       w_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    logic [JCNT_W-1:0]      j_reg,       j_next;
    logic [MCNT_W-1:0]      nmatch_reg,  nmatch_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   rsp_valid_reg,  rsp_valid_next;
    logic [KEY_CODES-1:0]   key_seen_reg,   key_seen_next;

    // Payload registers
    hcm_item_t              item_reg,       item_next;
    logic [IDX_W-1:0]       pend_slot_reg,  pend_slot_next;
    logic [GROUP_W-1:0]     pend_group_reg, pend_group_next;
    logic                   key_vld_reg,    key_vld_next;
    hcm_result_t            rsp_reg,        rsp_next;

    // Memory ports
    logic [0:0]             key_rdata;
    logic [KEY_ADDR_W-1:0]  key_sel;
    logic [$bits(hcm_entry_t)-1:0] combo_rdata;
    hcm_entry_t             entry;
    hcm_entry_t             add_entry;
    logic                   combo_we;
    logic [IDX_W-1:0]       combo_waddr;
    hcm_entry_t             combo_wdata;

    // Add evaluation
    logic [KEY_FIELDS-1:0][KEY_W-1:0] add_keys;
    logic                   add_bad;
    logic                   add_full;
    logic                   add_ok;

    assign entry   = hcm_entry_t'(combo_rdata);
    assign key_sel = entry.keys[j_reg[JIDX_W-1:0]];

    // Validate and pack a new combination
    always_comb
    begin
        add_keys = {item_reg.combo_key_d, item_reg.combo_key_c,
                    item_reg.combo_key_b, item_reg.combo_key_a};
        add_bad  = (item_reg.combo_size == '0) ||
                   (item_reg.combo_size > SIZE_W'(KEYS_USED_MAX));
        for (int k = 0; k < KEY_FIELDS; k++)
        begin
            if (SIZE_W'(k) < item_reg.combo_size)
            begin
                if (add_keys[k] == '0)
                begin
                    add_bad = 1'b1;
                end
            end
            else
            begin
                add_keys[k] = '0;
            end
        end
        add_entry.group = item_reg.group_tag;
        add_entry.size  = item_reg.combo_size;
        add_entry.keys  = add_keys;
    end

    assign add_full = (count_reg >= CNT_W'(MAX_COMBOS));
    assign add_ok   = !add_bad && !add_full;

    // Key-down map storage
    hcm_ram #(
        .WIDTH(1),
        .DEPTH(KEY_CODES)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.key_wr),
        .waddr (item_reg.key_code),
        .wdata (item_reg.kind == KIND_KEY_DOWN),
        .re    (cmd.key_rd),
        .raddr (key_sel),
        .rdata (key_rdata)
    );

    // Combination table storage
    assign combo_we    = (cmd.add_exec && add_ok) || cmd.rm_keep;
    assign combo_waddr = cmd.rm_keep ? w_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
    assign combo_wdata = cmd.rm_keep ? entry : add_entry;

    hcm_ram #(
        .WIDTH($bits(hcm_entry_t)),
        .DEPTH(MAX_COMBOS)
    ) u_combo_ram (
        .clk   (clk),
        .we    (combo_we),
        .waddr (combo_waddr),
        .wdata (combo_wdata),
        .re    (cmd.combo_rd),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (combo_rdata)
    );

    // Next-state logic
    always_comb
    begin
        item_next       = item_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        w_next          = w_reg;
        removed_next    = removed_reg;
        j_next          = j_reg;
        nmatch_next     = nmatch_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_group_next = pend_group_reg;
        key_seen_next   = key_seen_reg;
        key_vld_next    = key_vld_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = cmd.emit;

        // capture the accepted beat
        if (cmd.load)
        begin
            item_next = item;
        end

        // mark the key as written so its stored level counts
        if (cmd.key_wr)
        begin
            key_seen_next[item_reg.key_code] = 1'b1;
        end

        // restart the walk
        if (cmd.scan_clr)
        begin
            i_next          = '0;
            w_next          = '0;
            removed_next    = '0;
            nmatch_next     = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.combo_rd)
        begin
            j_next = '0;
        end

        // advance through the keys of the entry
        if (cmd.key_rd)
        begin
            j_next       = j_reg + JCNT_W'(1);
            key_vld_next = key_seen_reg[key_sel];
        end

        if (cmd.scan_step)
        begin
            i_next = i_reg + CNT_W'(1);
        end

        if (cmd.rm_keep)
        begin
            w_next = w_reg + CNT_W'(1);
        end

        if (cmd.rm_drop)
        begin
            removed_next = removed_reg + CNT_W'(1);
        end

        // hold the newest match until the next one or the end of the walk
        if (cmd.match)
        begin
            nmatch_next     = nmatch_reg + MCNT_W'(1);
            pend_valid_next = 1'b1;
            pend_slot_next  = i_reg[IDX_W-1:0];
            pend_group_next = entry.group;
        end

        if (cmd.add_exec && add_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.count_commit)
        begin
            count_next = w_reg;
        end

        // build the result beat
        if (cmd.emit)
        begin
            rsp_next = '0;
            unique case (cmd.emit_sel)
                EMIT_MATCH, EMIT_MATCH_LAST:
                begin
                    rsp_next.result_kind = RK_MATCH;
                    rsp_next.combo_slot  = SLOT_W'(pend_slot_reg);
                    rsp_next.combo_group = pend_group_reg;
                    rsp_next.last        = (cmd.emit_sel == EMIT_MATCH_LAST);
                end
                EMIT_ADD:
                begin
                    rsp_next.result_kind = RK_ADD;
                    rsp_next.last        = 1'b1;
                    priority if (add_bad)
                    begin
                        rsp_next.add_status = ST_INVALID;
                    end
                    else if (add_full)
                    begin
                        rsp_next.add_status = ST_FULL;
                    end
                    else
                    begin
                        rsp_next.add_status = ST_OK;
                        rsp_next.combo_slot = SLOT_W'(count_reg);
                    end
                end
                EMIT_REMOVE:
                begin
                    rsp_next.result_kind   = RK_REMOVE;
                    rsp_next.removed_count = RCOUNT_W'(removed_reg);
                    rsp_next.last          = 1'b1;
                end
                default:
                begin
                    rsp_next = rsp_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            removed_reg    <= '0;
            j_reg          <= '0;
            nmatch_reg     <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            key_seen_reg   <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            i_reg          <= i_next;
            w_reg          <= w_next;
            removed_reg    <= removed_next;
            j_reg          <= j_next;
            nmatch_reg     <= nmatch_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            key_seen_reg   <= key_seen_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pend_slot_reg  <= pend_slot_next;
        pend_group_reg <= pend_group_next;
        key_vld_reg    <= key_vld_next;
        rsp_reg        <= rsp_next;
    end

    // Status to the controller
    assign sts.kind        = item_kind_t'(item_reg.kind);
    assign sts.scan_done   = (i_reg == count_reg);
    assign sts.key_is_down = key_rdata[0] && key_vld_reg;
    assign sts.keys_done   = (SIZE_W'(j_reg) == entry.size);
    assign sts.group_hit   = (entry.group == item_reg.group_tag);
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.match_cap   = (nmatch_reg == MCNT_W'(MAX_RESULTS - 1));

    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

    // Table never holds more than its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_COMBOS))
        else $error("combination count above table capacity");

    // Compaction write pointer never passes the read pointer
    a_w_behind_i: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg <= i_reg)
        else $error("compaction write pointer ahead of read pointer");

endmodule

@@ src/hotkey_combo_matcher.sv @@
// ============================================================================
// hotkey_combo_matcher: key-down map with an ordered combination table
// Key down walks the table with one key-map RAM read per key checked;
// results cannot be stalled. Reset clears all keys to up and empties the
// table.
// ============================================================================
module hotkey_combo_matcher import hcm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hcm_item_t   item,
    output logic        result_valid,
    output hcm_result_t result
);

    hcm_cmd_t cmd;
    hcm_sts_t sts;

    // Sequencer
    hcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Storage and result formation
    hcm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    // A non-final beat always has more of the same walk behind it
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("non-final result beat with block idle");

    // The final beat of an item is never followed directly by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result beat directly after a final beat");

    // Add and remove answer with a single final beat
    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == RK_ADD ||
                         result.result_kind == RK_REMOVE) |-> result.last)
        else $error("status beat not marked final");

endmodule
